// ----- rtl/sle_pkg.sv -----
`default_nettype none
package sle_pkg;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_RM_LAST   = 3'd2,
		OP_RM_FIRST  = 3'd3,
		OP_RM_VALUE  = 3'd4,
		OP_RM_POS    = 3'd5,
		OP_REPLACE   = 3'd6,
		OP_COUNT     = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [31:0] ERR_RESULT = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ----- rtl/searchable_list_engine.sv -----
`default_nettype none
// Searchable list engine: an ordered list of signed 32-bit words, up to DEPTH
// entries, kept packed in one synchronous RAM with position 1 at address 0.
// The input channel (in_valid/in_ready) carries one command word: kind, value,
// old_value and position. The output channel (out_valid/out_ready) returns one
// word per command: result and status.
// One command is worked on at a time. in_ready is high in the idle state while
// the output register is empty or being drained in the same cycle, so a new
// command enters at the earliest in the cycle the previous word is taken.
// Insert at back, insert at front into an empty list, a refused insert and
// every removal that misses present their word in the cycle after acceptance.
// Other commands sweep the RAM with one read per cycle, the write-back of each
// word in the cycle after its read, and then present their word. The sweep
// reads the whole list for insert at front, remove by value and count, up to
// one word past the hit for replace (the whole list on a miss), and from the
// removed slot to the end for removals.
// Reset clears the length and the control state; the RAM is not cleared since
// only entries below the length are ever read. A stalled receiver holds the
// word in the output register and no new command is accepted until it is taken.
module searchable_list_engine
	import sle_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] value,
	input  wire logic [31:0] old_value,
	input  wire logic [6:0]  position,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result,
	output logic [1:0]       status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int PW = (LW > 7) ? LW : 7;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t          state_q, state_d;
	op_t             op_q, op_d;
	logic [31:0]     val_q, val_d;
	logic [31:0]     old_q, old_d;
	logic [31:0]     carry_q, carry_d;     // word taken out by a removal
	logic [LW-1:0]   len_q, len_d;
	logic [LW-1:0]   rd_q, rd_d;           // next read index
	logic [LW-1:0]   wr_q, wr_d;           // compaction write index
	logic [LW-1:0]   left_q, left_d;       // reads still to issue
	logic [LW-1:0]   pidx_q, pidx_d;       // index of the word in rdata
	logic [LW-1:0]   cnt_q, cnt_d;
	logic            pend_q, pend_d;       // rdata holds a word of the sweep
	logic            first_q, first_d;     // next word read is the first one
	logic            hit_q, hit_d;
	logic            out_valid_d;
	logic [31:0]     result_d;
	logic [1:0]      status_d;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [31:0]     wdata, rdata;

	logic [PW-1:0]   pos_w, len_w;
	logic [LW-1:0]   start_idx, pidx_inc;
	logic            in_fire, issue;

	assign pos_w    = PW'(position);
	assign len_w    = PW'(len_q);
	assign pidx_inc = pidx_q + LW'(1);
	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign issue    = (state_q == S_RUN) && (left_q != '0);
	assign raddr    = rd_q[AW-1:0];

	sle_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// First slot a removal reads: the word that leaves the list.
	always_comb begin
		unique case (op_t'(kind))
			OP_RM_LAST: start_idx = len_q - LW'(1);
			OP_RM_POS:  start_idx = LW'(pos_w - PW'(1));
			default:    start_idx = '0;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		val_d       = val_q;
		old_d       = old_q;
		carry_d     = carry_q;
		len_d       = len_q;
		rd_d        = rd_q;
		wr_d        = wr_q;
		left_d      = left_q;
		pidx_d      = pidx_q;
		cnt_d       = cnt_q;
		pend_d      = pend_q;
		first_d     = first_q;
		hit_d       = hit_q;
		out_valid_d = out_valid && !out_ready;
		result_d    = result;
		status_d    = status;
		we          = 1'b0;
		waddr       = '0;
		wdata       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_d    = op_t'(kind);
					val_d   = value;
					old_d   = old_value;
					cnt_d   = '0;
					pend_d  = 1'b0;
					first_d = 1'b1;
					hit_d   = 1'b0;
					unique case (op_t'(kind))
						OP_INS_FRONT, OP_INS_BACK: begin
							if (len_q >= LW'(DEPTH)) begin
								result_d    = ERR_RESULT;
								status_d    = ST_FULL;
								out_valid_d = 1'b1;
							end else if (op_t'(kind) == OP_INS_BACK || len_q == '0) begin
								// Appending, or the list is empty: no shift needed.
								we          = 1'b1;
								waddr       = len_q[AW-1:0];
								wdata       = value;
								len_d       = len_q + LW'(1);
								result_d    = '0;
								status_d    = ST_OK;
								out_valid_d = 1'b1;
							end else begin
								// Shift every word up by one, starting at the back.
								rd_d    = len_q - LW'(1);
								left_d  = len_q;
								state_d = S_RUN;
							end
						end
						OP_RM_LAST, OP_RM_FIRST, OP_RM_POS: begin
							if (len_q == '0 || (op_t'(kind) == OP_RM_POS &&
							    (pos_w == '0 || pos_w > len_w))) begin
								result_d    = ERR_RESULT;
								status_d    = ST_MISS;
								out_valid_d = 1'b1;
							end else begin
								rd_d    = start_idx;
								wr_d    = start_idx;
								left_d  = len_q - start_idx;
								state_d = S_RUN;
							end
						end
						default: begin
							rd_d    = '0;
							wr_d    = '0;
							left_d  = len_q;
							state_d = S_RUN;
						end
					endcase
				end
			end
			S_RUN: begin
				// Issue the next read while the previous word is consumed.
				pend_d = issue;
				pidx_d = rd_q;
				if (issue) begin
					left_d = left_q - LW'(1);
					rd_d   = (op_q == OP_INS_FRONT) ? rd_q - LW'(1) : rd_q + LW'(1);
				end
				if (pend_q) begin
					first_d = 1'b0;
					unique case (op_q)
						OP_INS_FRONT: begin
							we    = 1'b1;
							waddr = pidx_inc[AW-1:0];
							wdata = rdata;
						end
						OP_RM_LAST, OP_RM_FIRST, OP_RM_POS: begin
							if (first_q) begin
								carry_d = rdata;
							end else begin
								we    = 1'b1;
								waddr = wr_q[AW-1:0];
								wdata = rdata;
								wr_d  = wr_q + LW'(1);
							end
						end
						OP_RM_VALUE: begin
							if (rdata == val_q) begin
								cnt_d = cnt_q + LW'(1);
							end else begin
								we    = 1'b1;
								waddr = wr_q[AW-1:0];
								wdata = rdata;
								wr_d  = wr_q + LW'(1);
							end
						end
						OP_REPLACE: begin
							// Only the first match is replaced; later reads are ignored.
							if (!hit_q && rdata == old_q) begin
								we     = 1'b1;
								waddr  = pidx_q[AW-1:0];
								wdata  = val_q;
								hit_d  = 1'b1;
								left_d = '0;
							end
						end
						default: begin
							if (rdata == val_q) begin
								cnt_d = cnt_q + LW'(1);
							end
						end
					endcase
				end
				if (!issue) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				out_valid_d = 1'b1;
				status_d    = ST_OK;
				state_d     = S_IDLE;
				unique case (op_q)
					OP_INS_FRONT: begin
						// The shift has cleared slot 0 for the new word.
						we       = 1'b1;
						waddr    = '0;
						wdata    = val_q;
						len_d    = len_q + LW'(1);
						result_d = '0;
					end
					OP_RM_LAST, OP_RM_FIRST, OP_RM_POS: begin
						len_d    = len_q - LW'(1);
						result_d = carry_q;
					end
					OP_RM_VALUE: begin
						len_d    = len_q - cnt_q;
						result_d = 32'(cnt_q);
					end
					OP_REPLACE: begin
						result_d = hit_q ? 32'd0 : ERR_RESULT;
						status_d = hit_q ? ST_OK : ST_MISS;
					end
					default: result_d = 32'(cnt_q);
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_INS_FRONT;
			val_q     <= '0;
			old_q     <= '0;
			carry_q   <= '0;
			len_q     <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			left_q    <= '0;
			pidx_q    <= '0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			first_q   <= 1'b0;
			hit_q     <= 1'b0;
			out_valid <= 1'b0;
			result    <= '0;
			status    <= ST_OK;
		end else begin
			state_q   <= state_d;
			op_q      <= op_d;
			val_q     <= val_d;
			old_q     <= old_d;
			carry_q   <= carry_d;
			len_q     <= len_d;
			rd_q      <= rd_d;
			wr_q      <= wr_d;
			left_q    <= left_d;
			pidx_q    <= pidx_d;
			cnt_q     <= cnt_d;
			pend_q    <= pend_d;
			first_q   <= first_d;
			hit_q     <= hit_d;
			out_valid <= out_valid_d;
			result    <= result_d;
			status    <= status_d;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(DEPTH)) else $error("length beyond depth");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result) && $stable(status))
		else $error("result changed while waiting");

endmodule
`default_nettype wire

// ----- rtl/sle_ram.sv -----
`default_nettype none
module sle_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
